>>> sv/clx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_pkg
// Shared types, token codes and operator decode for the C source lexer.
// ----------------------------------------------------------------------------
package clx_pkg;

    localparam int DEF_TABLE_ENTRIES = 128;
    localparam int DEF_NAME_BYTES    = 32;
    localparam int NAME_LEN_W        = 9;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [4:0] K_ID      = 5'd0;
    localparam logic [4:0] K_NUM     = 5'd1;
    localparam logic [4:0] K_DIV     = 5'd2;
    localparam logic [4:0] K_EQ      = 5'd3;
    localparam logic [4:0] K_ASSIGN  = 5'd4;
    localparam logic [4:0] K_INC     = 5'd5;
    localparam logic [4:0] K_ADD     = 5'd6;
    localparam logic [4:0] K_DEC     = 5'd7;
    localparam logic [4:0] K_SUB     = 5'd8;
    localparam logic [4:0] K_NE      = 5'd9;
    localparam logic [4:0] K_LE      = 5'd10;
    localparam logic [4:0] K_SHL     = 5'd11;
    localparam logic [4:0] K_LT      = 5'd12;
    localparam logic [4:0] K_GE      = 5'd13;
    localparam logic [4:0] K_SHR     = 5'd14;
    localparam logic [4:0] K_GT      = 5'd15;
    localparam logic [4:0] K_LOR     = 5'd16;
    localparam logic [4:0] K_OR      = 5'd17;
    localparam logic [4:0] K_LAND    = 5'd18;
    localparam logic [4:0] K_AND     = 5'd19;
    localparam logic [4:0] K_XOR     = 5'd20;
    localparam logic [4:0] K_MOD     = 5'd21;
    localparam logic [4:0] K_MUL     = 5'd22;
    localparam logic [4:0] K_BRACKET = 5'd23;
    localparam logic [4:0] K_PUNCT   = 5'd24;
    localparam logic [4:0] K_NONE    = 5'd31;

    typedef struct packed {
        logic                  ident;
        logic [4:0]            kind;
        logic [31:0]           value;
        logic [NAME_LEN_W-1:0] len;
        logic                  last;
    } tok_t;

    function automatic tok_t mk_tok(input logic ident, input logic [4:0] kind,
                                    input logic [31:0] value,
                                    input logic [NAME_LEN_W-1:0] len);
        tok_t t;
        t.ident = ident;
        t.kind  = kind;
        t.value = value;
        t.len   = len;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] p);
        logic [4:0] k;
        case (p)
            "=": k = K_ASSIGN;
            "+": k = K_ADD;
            "-": k = K_SUB;
            "<": k = K_LT;
            ">": k = K_GT;
            "|": k = K_OR;
            "&": k = K_AND;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [4:0] k;
        k = K_NONE;
        if (p == "=" && c == "=") k = K_EQ;
        if (p == "+" && c == "+") k = K_INC;
        if (p == "-" && c == "-") k = K_DEC;
        if (p == "!" && c == "=") k = K_NE;
        if (p == "<" && c == "=") k = K_LE;
        if (p == "<" && c == "<") k = K_SHL;
        if (p == ">" && c == "=") k = K_GE;
        if (p == ">" && c == ">") k = K_SHR;
        if (p == "|" && c == "|") k = K_LOR;
        if (p == "&" && c == "&") k = K_LAND;
        return k;
    endfunction

endpackage
`default_nettype wire

>>> sv/clx_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module clx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/clx_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_queue
// Small token queue between the lexer front and the table back end.
// ----------------------------------------------------------------------------
module clx_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

>>> sv/clx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_front
// Lexer front: scans one byte per word, tracks the lexing mode and queues
// up to three tokens per byte. Identifier names go to the name buffer.
// ----------------------------------------------------------------------------
module clx_front
    import clx_pkg::*;
#(
    parameter int NAME_BYTES = DEF_NAME_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_in_byte,
    input  wire logic                          s_end_of_source,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output tok_t                               q_data,
    output logic                               nb_we,
    output logic [$clog2(NAME_BYTES)-1:0]      nb_waddr,
    output logic [7:0]                         nb_wdata,
    input  wire logic                          id_done
);
    localparam int LW = $clog2(NAME_BYTES + 1);
    localparam int BW = $clog2(NAME_BYTES);

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_HASHLINE  = 4'd1;
    localparam logic [3:0] M_IDENT     = 4'd2;
    localparam logic [3:0] M_NUMBER    = 4'd3;
    localparam logic [3:0] M_QUOTE     = 4'd4;
    localparam logic [3:0] M_QESC      = 4'd5;
    localparam logic [3:0] M_SLASH     = 4'd6;
    localparam logic [3:0] M_LINECMT   = 4'd7;
    localparam logic [3:0] M_BLOCK     = 4'd8;
    localparam logic [3:0] M_BLOCKSTAR = 4'd9;
    localparam logic [3:0] M_OP        = 4'd10;

    logic [3:0]    mode_reg, mode_next;
    logic [31:0]   hash_reg, hash_next;
    logic [LW-1:0] len_reg, len_next;
    logic [31:0]   num_reg, num_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    quote_reg, quote_next;
    logic [7:0]    lit_reg, lit_next;
    tok_t          stg_reg [3];
    tok_t          stg_next [3];
    logic [1:0]    cnt_reg, cnt_next, rd_reg, rd_next;
    logic          busy_reg, busy_next;

    logic [7:0] c;
    logic       acc, is_alpha, is_digit, is_opch, do_start;
    logic [3:0] sb_mode;
    logic       sb_emit;
    logic [4:0] sb_kind, pk, sk;
    tok_t       cand [3];
    logic [2:0] cand_v;
    logic [1:0] n;
    logic       any_id;

    assign c        = s_in_byte;
    assign s_ready  = (rd_reg == cnt_reg) && !busy_reg;
    assign acc      = s_valid && s_ready;
    assign q_valid  = (rd_reg != cnt_reg);
    assign q_data   = stg_reg[rd_reg];
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign is_digit = (c >= "0" && c <= "9");
    assign is_opch  = c == "=" || c == "+" || c == "-" || c == "!" || c == "<" ||
                      c == ">" || c == "|" || c == "&";

    always_comb begin
        sb_mode = M_IDLE;
        sb_emit = 1'b0;
        sb_kind = K_PUNCT;
        if (c == "#") begin
            sb_mode = M_HASHLINE;
        end else if (is_alpha) begin
            sb_mode = M_IDENT;
        end else if (is_digit) begin
            sb_mode = M_NUMBER;
        end else if (c == "\"" || c == "'") begin
            sb_mode = M_QUOTE;
        end else if (c == "/") begin
            sb_mode = M_SLASH;
        end else if (is_opch) begin
            sb_mode = M_OP;
        end else if (c == "^") begin
            sb_emit = 1'b1;
            sb_kind = K_XOR;
        end else if (c == "%") begin
            sb_emit = 1'b1;
            sb_kind = K_MOD;
        end else if (c == "*") begin
            sb_emit = 1'b1;
            sb_kind = K_MUL;
        end else if (c == "[") begin
            sb_emit = 1'b1;
            sb_kind = K_BRACKET;
        end else if (c == "~" || c == ";" || c == "{" || c == "}" || c == "(" ||
                     c == ")" || c == "]" || c == "," || c == ":") begin
            sb_emit = 1'b1;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        hash_next  = hash_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        pend_next  = pend_reg;
        quote_next = quote_reg;
        lit_next   = lit_reg;
        nb_we      = 1'b0;
        nb_waddr   = len_reg[BW-1:0];
        nb_wdata   = c;
        do_start   = 1'b0;
        cand_v     = '0;
        for (int k = 0; k < 3; k++) begin
            cand[k] = mk_tok(1'b0, K_NUM, 32'd0, '0);
        end
        pk = pair_kind(pend_reg, c);
        sk = single_kind(pend_reg);

        case (mode_reg)
            M_HASHLINE, M_LINECMT: begin
                if (c == 8'h0A) mode_next = M_IDLE;
            end
            M_BLOCK: begin
                if (c == "*") mode_next = M_BLOCKSTAR;
            end
            M_BLOCKSTAR: begin
                if (c == "/") mode_next = M_IDLE;
                else if (c != "*") mode_next = M_BLOCK;
            end
            M_QUOTE: begin
                if (c == quote_reg) begin
                    cand_v[0] = (quote_reg == "'");
                    cand[0]   = mk_tok(1'b0, K_NUM, {24'd0, lit_reg}, '0);
                    mode_next = M_IDLE;
                end else if (c == "\\") begin
                    mode_next = M_QESC;
                end else begin
                    lit_next = c;
                end
            end
            M_QESC: begin
                lit_next  = (c == "n") ? 8'h0A : c;
                mode_next = M_QUOTE;
            end
            M_IDENT: begin
                if (is_alpha || is_digit) begin
                    hash_next = hash_reg * 32'd147 + {24'd0, c};
                    if (len_reg < LW'(NAME_BYTES)) begin
                        nb_we    = acc;
                        len_next = len_reg + 1'b1;
                    end
                end else begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(1'b1, K_ID, hash_reg, NAME_LEN_W'(len_reg));
                    do_start  = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit) begin
                    num_next = num_reg * 32'd10 + {28'd0, c[3:0]};
                end else begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(1'b0, K_NUM, num_reg, '0);
                    do_start  = 1'b1;
                end
            end
            M_SLASH: begin
                if (c == "/") begin
                    mode_next = M_LINECMT;
                end else if (c == "*") begin
                    mode_next = M_BLOCK;
                end else begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(1'b0, K_DIV, 32'd0, '0);
                    do_start  = 1'b1;
                end
            end
            M_OP: begin
                if (pk != K_NONE) begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(1'b0, pk, 32'd0, '0);
                    mode_next = M_IDLE;
                end else begin
                    cand_v[0] = (sk != K_NONE);
                    cand[0]   = mk_tok(1'b0, sk, 32'd0, '0);
                    do_start  = 1'b1;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        if (do_start) begin
            mode_next = sb_mode;
            if (is_alpha) begin
                hash_next = {24'd0, c};
                len_next  = LW'(1);
                nb_we     = acc;
                nb_waddr  = '0;
            end else if (is_digit) begin
                num_next = {28'd0, c[3:0]};
            end else if (c == "\"" || c == "'") begin
                quote_next = c;
                lit_next   = 8'd0;
            end else if (is_opch) begin
                pend_next = c;
            end
            cand_v[1] = sb_emit;
            cand[1]   = mk_tok(1'b0, sb_kind,
                               (sb_kind == K_PUNCT) ? {24'd0, c} : 32'd0, '0);
        end

        if (s_end_of_source) begin
            case (mode_next)
                M_IDENT: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk_tok(1'b1, K_ID, hash_next, NAME_LEN_W'(len_next));
                end
                M_NUMBER: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk_tok(1'b0, K_NUM, num_next, '0);
                end
                M_SLASH: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk_tok(1'b0, K_DIV, 32'd0, '0);
                end
                M_OP: begin
                    cand_v[2] = (single_kind(pend_next) != K_NONE);
                    cand[2]   = mk_tok(1'b0, single_kind(pend_next), 32'd0, '0);
                end
                M_QUOTE, M_QESC: begin
                    cand_v[2] = (quote_next == "'");
                    cand[2]   = mk_tok(1'b0, K_NUM, {24'd0, lit_next}, '0);
                end
                default: begin
                end
            endcase
            mode_next = M_IDLE;
        end
    end

    always_comb begin
        n      = '0;
        any_id = 1'b0;
        for (int k = 0; k < 3; k++) begin
            stg_next[k] = stg_reg[k];
        end
        for (int k = 0; k < 3; k++) begin
            if (cand_v[k]) begin
                stg_next[n] = cand[k];
                any_id      = any_id | cand[k].ident;
                n           = n + 1'b1;
            end
        end
        if (n != '0) begin
            stg_next[n - 1'b1].last = 1'b1;
        end
        cnt_next  = cnt_reg;
        rd_next   = rd_reg;
        busy_next = busy_reg && !id_done;
        if (acc) begin
            cnt_next  = n;
            rd_next   = '0;
            busy_next = any_id;
        end else if (q_valid && q_ready) begin
            rd_next = rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            hash_reg  <= '0;
            len_reg   <= '0;
            num_reg   <= '0;
            pend_reg  <= '0;
            quote_reg <= '0;
            lit_reg   <= '0;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            busy_reg  <= 1'b0;
        end else begin
            if (acc) begin
                mode_reg  <= mode_next;
                hash_reg  <= hash_next;
                len_reg   <= len_next;
                num_reg   <= num_next;
                pend_reg  <= pend_next;
                quote_reg <= quote_next;
                lit_reg   <= lit_next;
            end
            cnt_reg  <= cnt_next;
            rd_reg   <= rd_next;
            busy_reg <= busy_next;
        end
        if (acc) begin
            for (int k = 0; k < 3; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/clx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_back
// Back end: passes plain tokens to the output register and resolves
// identifiers against the intern table (hash, length, then name bytes).
// ----------------------------------------------------------------------------
module clx_back
    import clx_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int NAME_BYTES    = DEF_NAME_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  tok_t                               q_data,
    output logic [$clog2(NAME_BYTES)-1:0]      nb_raddr,
    input  wire logic [7:0]                    nb_rdata,
    output logic                               id_done,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [4:0]                         m_token_kind,
    output logic [31:0]                        m_token_value,
    output logic                               m_table_full,
    output logic                               m_last_of_run
);
    localparam int LW = $clog2(NAME_BYTES + 1);
    localparam int BW = $clog2(NAME_BYTES);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = $clog2(TABLE_ENTRIES * NAME_BYTES);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_HREQ = 3'd1;
    localparam logic [2:0] B_HCHK = 3'd2;
    localparam logic [2:0] B_NREQ = 3'd3;
    localparam logic [2:0] B_NCHK = 3'd4;
    localparam logic [2:0] B_NEW  = 3'd5;
    localparam logic [2:0] B_COPY = 3'd6;
    localparam logic [2:0] B_EMIT = 3'd7;

    logic [2:0]    st_reg, st_next;
    logic [31:0]   hash_reg, hash_next;
    logic [LW-1:0] len_reg, len_next, j_reg, j_next;
    logic          last_reg, last_next;
    logic [UW-1:0] i_reg, i_next, used_reg, used_next;
    logic [AW-1:0] base_reg, base_next;
    logic [31:0]   res_reg, res_next;
    logic          full_reg, full_next;
    logic          cwr_reg, cwr_next;

    logic          ov_reg, ov_next, ol_reg, ol_next, of_reg, of_next;
    logic [4:0]    ok_reg, ok_next;
    logic [31:0]   oval_reg, oval_next;
    logic          out_free;

    logic          tw_we, nm_we;
    logic [31:0]   h_rd;
    logic [LW-1:0] l_rd;
    logic [7:0]    n_rd;
    logic [AW-1:0] n_addr;

    assign out_free      = !ov_reg || m_ready;
    assign m_valid       = ov_reg;
    assign m_token_kind  = ok_reg;
    assign m_token_value = oval_reg;
    assign m_table_full  = of_reg;
    assign m_last_of_run = ol_reg;
    assign nb_raddr      = j_reg[BW-1:0];
    assign n_addr        = base_reg + AW'(j_reg);
    assign q_ready       = (st_reg == B_IDLE) && (q_data.ident || out_free);

    clx_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_hash (
        .aclk(aclk), .we(tw_we), .waddr(used_reg[IW-1:0]), .wdata(hash_reg),
        .raddr(i_reg[IW-1:0]), .rdata(h_rd)
    );
    clx_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_len (
        .aclk(aclk), .we(tw_we), .waddr(used_reg[IW-1:0]), .wdata(len_reg),
        .raddr(i_reg[IW-1:0]), .rdata(l_rd)
    );
    clx_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * NAME_BYTES)) u_names (
        .aclk(aclk), .we(nm_we), .waddr(n_addr), .wdata(nb_rdata),
        .raddr(n_addr), .rdata(n_rd)
    );

    always_comb begin
        st_next   = st_reg;
        hash_next = hash_reg;
        len_next  = len_reg;
        j_next    = j_reg;
        last_next = last_reg;
        i_next    = i_reg;
        used_next = used_reg;
        base_next = base_reg;
        res_next  = res_reg;
        full_next = full_reg;
        cwr_next  = 1'b0;
        ov_next   = ov_reg && !m_ready;
        ok_next   = ok_reg;
        oval_next = oval_reg;
        of_next   = of_reg;
        ol_next   = ol_reg;
        tw_we     = 1'b0;
        nm_we     = 1'b0;
        id_done   = 1'b0;

        case (st_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_data.ident) begin
                        hash_next = q_data.value;
                        len_next  = q_data.len[LW-1:0];
                        last_next = q_data.last;
                        i_next    = '0;
                        base_next = '0;
                        j_next    = '0;
                        st_next   = (used_reg == '0) ? B_NEW : B_HREQ;
                    end else if (out_free) begin
                        ov_next   = 1'b1;
                        ok_next   = q_data.kind;
                        oval_next = q_data.value;
                        of_next   = 1'b0;
                        ol_next   = q_data.last;
                    end
                end
            end
            B_HREQ: begin
                st_next = B_HCHK;
            end
            B_HCHK: begin
                if (h_rd == hash_reg && l_rd == len_reg) begin
                    j_next  = '0;
                    st_next = B_NREQ;
                end else begin
                    i_next    = i_reg + 1'b1;
                    base_next = base_reg + AW'(NAME_BYTES);
                    st_next   = (i_reg + 1'b1 == used_reg) ? B_NEW : B_HREQ;
                end
            end
            B_NREQ: begin
                st_next = B_NCHK;
            end
            B_NCHK: begin
                if (n_rd != nb_rdata) begin
                    i_next    = i_reg + 1'b1;
                    base_next = base_reg + AW'(NAME_BYTES);
                    st_next   = (i_reg + 1'b1 == used_reg) ? B_NEW : B_HREQ;
                end else if (j_reg + 1'b1 == len_reg) begin
                    res_next  = 32'(i_reg);
                    full_next = 1'b0;
                    st_next   = B_EMIT;
                end else begin
                    j_next  = j_reg + 1'b1;
                    st_next = B_NREQ;
                end
            end
            B_NEW: begin
                j_next = '0;
                if (used_reg < UW'(TABLE_ENTRIES)) begin
                    res_next  = 32'(used_reg);
                    full_next = 1'b0;
                    st_next   = B_COPY;
                end else begin
                    res_next  = 32'd0;
                    full_next = 1'b1;
                    st_next   = B_EMIT;
                end
            end
            B_COPY: begin
                // alternate: read name buffer byte, then write it into the table
                if (!cwr_reg) begin
                    cwr_next = 1'b1;
                end else begin
                    nm_we = 1'b1;
                    if (j_reg + 1'b1 == len_reg) begin
                        tw_we     = 1'b1;
                        used_next = used_reg + 1'b1;
                        st_next   = B_EMIT;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    ov_next   = 1'b1;
                    ok_next   = K_ID;
                    oval_next = res_reg;
                    of_next   = full_reg;
                    ol_next   = last_reg;
                    id_done   = 1'b1;
                    st_next   = B_IDLE;
                end
            end
            default: begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= B_IDLE;
            used_reg <= '0;
            ov_reg   <= 1'b0;
            cwr_reg  <= 1'b0;
        end else begin
            st_reg   <= st_next;
            used_reg <= used_next;
            ov_reg   <= ov_next;
            cwr_reg  <= cwr_next;
        end
        hash_reg <= hash_next;
        len_reg  <= len_next;
        j_reg    <= j_next;
        last_reg <= last_next;
        i_reg    <= i_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        full_reg <= full_next;
        ok_reg   <= ok_next;
        oval_reg <= oval_next;
        of_reg   <= of_next;
        ol_reg   <= ol_next;
    end
endmodule
`default_nettype wire

>>> sv/c_source_lexer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_source_lexer_core
// Streaming C lexer with an identifier intern table.
// ----------------------------------------------------------------------------
// Takes one source byte per word and returns tokens, up to three per byte,
// the final one marked by m_last_of_run. A byte that yields no token leaves
// the input ready for the next byte; a byte that yields tokens holds the
// input while they move into the queue. A byte that closes an identifier
// holds the input until the table search is done: it visits the stored
// entries, compares the name bytes on a hash and length match, and for a
// new name copies it in byte by byte, with the read and write ports of the
// name table on one address. A queue of QUEUE_DEPTH tokens sits between the
// lexer and the table logic. When the table is full a new name returns
// index 0 with m_table_full set.
// ----------------------------------------------------------------------------
module c_source_lexer_core
    import clx_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int NAME_BYTES    = DEF_NAME_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_end_of_source,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_token_kind,
    output logic [31:0]      m_token_value,
    output logic             m_table_full,
    output logic             m_last_of_run
);
    localparam int BW = $clog2(NAME_BYTES);

    tok_t          fq_data, qb_data;
    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    logic          nb_we, id_done;
    logic [BW-1:0] nb_waddr, nb_raddr;
    logic [7:0]    nb_wdata, nb_rdata;

    clx_front #(.NAME_BYTES(NAME_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_byte(s_in_byte), .s_end_of_source(s_end_of_source),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data),
        .nb_we(nb_we), .nb_waddr(nb_waddr), .nb_wdata(nb_wdata),
        .id_done(id_done)
    );

    clx_queue #(.WIDTH($bits(tok_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    clx_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_namebuf (
        .aclk(aclk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
        .raddr(nb_raddr), .rdata(nb_rdata)
    );

    clx_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .NAME_BYTES(NAME_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .nb_raddr(nb_raddr), .nb_rdata(nb_rdata), .id_done(id_done),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_token_value(m_token_value),
        .m_table_full(m_table_full), .m_last_of_run(m_last_of_run)
    );

    a_full_is_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> m_token_kind == K_ID && m_token_value == 32'd0)
        else $error("table_full on a non-identifier word");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= K_PUNCT)
        else $error("token kind out of range");

    a_op_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != K_ID && m_token_kind != K_NUM &&
        m_token_kind != K_PUNCT |-> m_token_value == 32'd0)
        else $error("operator word carries a value");
endmodule
`default_nettype wire

>>> tb/sv/c_source_lexer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_lexer_core_tb
// Self-checking bench for the streaming C lexer.
// ----------------------------------------------------------------------------
// Feeds source text one byte per word and predicts the token stream with a
// behavioral lexer and intern table kept inside the bench. Every returned
// token is checked field by field against the oldest prediction. It covers
// directed cases, random well-formed C fragments mixed with noise, output
// back-pressure and a sender pause.
// ----------------------------------------------------------------------------
module c_source_lexer_core_tb;
    import clx_pkg::*;

    localparam int TBL_N  = DEF_TABLE_ENTRIES;
    localparam int NAME_N = DEF_NAME_BYTES;

    typedef enum logic [3:0] {
        LX_IDLE, LX_HASHLINE, LX_IDENT, LX_NUMBER, LX_QUOTE, LX_QESC,
        LX_SLASH, LX_LINECMT, LX_BLOCK, LX_BLOCKSTAR, LX_OP
    } lx_mode_e;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic        full;
        logic        last;
    } token_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_end_of_source;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_token_kind;
    logic [31:0] m_token_value;
    logic        m_table_full;
    logic        m_last_of_run;

    c_source_lexer_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_byte(s_in_byte), .s_end_of_source(s_end_of_source),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_token_value(m_token_value),
        .m_table_full(m_table_full), .m_last_of_run(m_last_of_run)
    );

    // lexer state mirror
    lx_mode_e    mode;
    logic [31:0] run_hash;
    logic [7:0]  name_buf [NAME_N];
    int          name_len;
    logic [31:0] num_acc;
    logic [7:0]  pend_op;
    logic [7:0]  quote_ch;
    logic [7:0]  lit_ch;
    logic [31:0] tbl_hash [TBL_N];
    logic [7:0]  tbl_name [TBL_N][NAME_N];
    int          tbl_len  [TBL_N];
    int          tbl_used;

    token_t      token_q[$];
    int          step_cnt;
    int          errors;
    int          words_sent;
    int          tokens_seen;
    int          full_seen;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          rx_hold;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(4ns * 2000000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] op_single(input logic [7:0] p);
        case (p)
            "=": return K_ASSIGN;
            "+": return K_ADD;
            "-": return K_SUB;
            "<": return K_LT;
            ">": return K_GT;
            "|": return K_OR;
            "&": return K_AND;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [4:0] op_pair(input logic [7:0] p, input logic [7:0] c);
        if (p == "=" && c == "=") return K_EQ;
        if (p == "+" && c == "+") return K_INC;
        if (p == "-" && c == "-") return K_DEC;
        if (p == "!" && c == "=") return K_NE;
        if (p == "<" && c == "=") return K_LE;
        if (p == "<" && c == "<") return K_SHL;
        if (p == ">" && c == "=") return K_GE;
        if (p == ">" && c == ">") return K_SHR;
        if (p == "|" && c == "|") return K_LOR;
        if (p == "&" && c == "&") return K_LAND;
        return K_NONE;
    endfunction

    function automatic void push_token(input logic [4:0] k, input logic [31:0] v,
                                       input logic f);
        token_t t;
        if (step_cnt >= 3) return;
        t.kind = k; t.value = v; t.full = f; t.last = 1'b0;
        token_q.push_back(t);
        step_cnt++;
    endfunction

    function automatic void intern_name();
        bit hit;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_hash[i] == run_hash && tbl_len[i] == name_len) begin
                hit = 1'b1;
                for (int j = 0; j < name_len; j++)
                    if (tbl_name[i][j] != name_buf[j]) hit = 1'b0;
                if (hit) begin
                    push_token(K_ID, 32'(i), 1'b0);
                    return;
                end
            end
        end
        if (tbl_used < TBL_N) begin
            for (int j = 0; j < name_len; j++) tbl_name[tbl_used][j] = name_buf[j];
            tbl_hash[tbl_used] = run_hash;
            tbl_len[tbl_used]  = name_len;
            push_token(K_ID, 32'(tbl_used), 1'b0);
            tbl_used++;
        end else begin
            push_token(K_ID, 32'd0, 1'b1);
        end
    endfunction

    function automatic void add_name_ch(input logic [7:0] c);
        if (name_len < NAME_N) begin
            name_buf[name_len] = c;
            name_len++;
        end
    endfunction

    function automatic void begin_token(input logic [7:0] c);
        mode = LX_IDLE;
        if (c == "#") mode = LX_HASHLINE;
        else if (is_alpha(c)) begin
            run_hash = {24'd0, c}; name_len = 0; add_name_ch(c); mode = LX_IDENT;
        end else if (is_digit(c)) begin
            num_acc = {24'd0, 8'(c - "0")}; mode = LX_NUMBER;
        end else if (c == "\"" || c == "'") begin
            quote_ch = c; lit_ch = 8'd0; mode = LX_QUOTE;
        end else if (c == "/") mode = LX_SLASH;
        else if (c == "=" || c == "+" || c == "-" || c == "!" || c == "<" ||
                 c == ">" || c == "|" || c == "&") begin
            pend_op = c; mode = LX_OP;
        end else if (c == "^") push_token(K_XOR, 32'd0, 1'b0);
        else if (c == "%") push_token(K_MOD, 32'd0, 1'b0);
        else if (c == "*") push_token(K_MUL, 32'd0, 1'b0);
        else if (c == "[") push_token(K_BRACKET, 32'd0, 1'b0);
        else if (c == "~" || c == ";" || c == "{" || c == "}" || c == "(" ||
                 c == ")" || c == "]" || c == "," || c == ":")
            push_token(K_PUNCT, {24'd0, c}, 1'b0);
    endfunction

    function automatic void flush_op();
        if (op_single(pend_op) != K_NONE) push_token(op_single(pend_op), 32'd0, 1'b0);
    endfunction

    // predicts the tokens caused by one accepted word
    function automatic void lex_byte(input logic [7:0] c, input logic eos);
        logic [4:0] k;
        int first;
        first = token_q.size();
        step_cnt = 0;
        case (mode)
            LX_HASHLINE, LX_LINECMT: if (c == 8'h0a) mode = LX_IDLE;
            LX_BLOCK: if (c == "*") mode = LX_BLOCKSTAR;
            LX_BLOCKSTAR: begin
                if (c == "/") mode = LX_IDLE;
                else if (c != "*") mode = LX_BLOCK;
            end
            LX_QUOTE: begin
                if (c == quote_ch) begin
                    if (quote_ch == "'") push_token(K_NUM, {24'd0, lit_ch}, 1'b0);
                    mode = LX_IDLE;
                end else if (c == "\\") mode = LX_QESC;
                else lit_ch = c;
            end
            LX_QESC: begin
                lit_ch = (c == "n") ? 8'd10 : c;
                mode = LX_QUOTE;
            end
            LX_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    run_hash = run_hash * 32'd147 + {24'd0, c};
                    add_name_ch(c);
                end else begin
                    intern_name();
                    begin_token(c);
                end
            end
            LX_NUMBER: begin
                if (is_digit(c)) num_acc = num_acc * 32'd10 + {24'd0, 8'(c - "0")};
                else begin
                    push_token(K_NUM, num_acc, 1'b0);
                    begin_token(c);
                end
            end
            LX_SLASH: begin
                if (c == "/") mode = LX_LINECMT;
                else if (c == "*") mode = LX_BLOCK;
                else begin
                    push_token(K_DIV, 32'd0, 1'b0);
                    begin_token(c);
                end
            end
            LX_OP: begin
                k = op_pair(pend_op, c);
                if (k != K_NONE) begin
                    push_token(k, 32'd0, 1'b0);
                    mode = LX_IDLE;
                end else begin
                    flush_op();
                    begin_token(c);
                end
            end
            default: begin_token(c);
        endcase
        if (eos) begin
            case (mode)
                LX_IDENT:  intern_name();
                LX_NUMBER: push_token(K_NUM, num_acc, 1'b0);
                LX_SLASH:  push_token(K_DIV, 32'd0, 1'b0);
                LX_OP:     flush_op();
                LX_QUOTE, LX_QESC:
                    if (quote_ch == "'") push_token(K_NUM, {24'd0, lit_ch}, 1'b0);
                default: ;
            endcase
            mode = LX_IDLE;
        end
        if (token_q.size() > first) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // result checker
    always @(posedge aclk) begin
        token_t exp_t;
        if (aresetn && m_valid && m_ready) begin
            tokens_seen++;
            if (m_table_full) full_seen++;
            if (token_q.size() == 0) begin
                errors++;
                $display("%t: unexpected token kind=%0d value=%0d", $realtime,
                         m_token_kind, m_token_value);
            end else begin
                exp_t = token_q.pop_front();
                if (m_token_kind !== exp_t.kind || m_token_value !== exp_t.value ||
                    m_table_full !== exp_t.full || m_last_of_run !== exp_t.last) begin
                    errors++;
                    $display("%t: mismatch exp kind=%0d value=%0d full=%0b last=%0b",
                             $realtime, exp_t.kind, exp_t.value, exp_t.full, exp_t.last);
                    $display("%t:          act kind=%0d value=%0d full=%0b last=%0b",
                             $realtime, m_token_kind, m_token_value, m_table_full,
                             m_last_of_run);
                end
            end
        end
    end

    // receiver: random stalls plus a counted hold-off
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= !(rx_idle_en && $urandom_range(0, 99) < 7);
        end
    end

    task automatic send_word(input logic [7:0] c, input logic eos);
        while (tx_idle_en && $urandom_range(0, 99) < 7) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_in_byte <= 8'($urandom);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_in_byte <= c;
        s_end_of_source <= eos;
        do @(posedge aclk); while (!s_ready);
        lex_byte(c, eos);
        words_sent++;
    endtask

    task automatic send_text(input string s, input bit eos_at_end);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], eos_at_end && i == s.len() - 1);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_text("a==b!=c<=d<<e>=f>>g||h&&i|j&k^l%m[n]~{(),:}<>-- ++!x", 0);
        send_text("#x\nz/2//c\ny/*a**/w", 0);
        send_text("'\\n''a''''\\''\"q\\\"x\" 4294967296", 1);
        send_text("'b", 1);
        send_text("\"a", 1);
        send_text("-", 1);
        send_text("/", 1);
        send_text("! ", 1);
        send_word(8'h00, 0);
        send_word(8'hff, 1);
        send_text("abcdefghijklmnopqrstuvwxyz0123456 abcdefghijklmnopqrstuvwxyz0123456", 1);
    endtask

    function automatic string rand_fragment();
        string ops[] = '{"==", "=", "++", "+", "--", "-", "!=", "<=", "<<", "<",
                         ">=", ">>", ">", "||", "|", "&&", "&", "^", "%", "*",
                         "[", "/", ";", "{", "}", "(", ")", "]", ",", ":", "~"};
        string ids[] = '{"i", "n", "foo", "Bar_1", "x", "_t", "count"};
        string s;
        int n;
        case ($urandom_range(0, 11))
            0, 1: s = ids[$urandom_range(0, ids.size() - 1)];
            2: begin
                n = $urandom_range(1, 6);
                s = "";
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                                           : "0" + $urandom_range(0, 9)))};
                s = {"v", s};
            end
            3: s = $sformatf("%0d", $urandom);
            4, 5: s = ops[$urandom_range(0, ops.size() - 1)];
            6: s = $sformatf("'%s'", $urandom_range(0, 1) ? "\\n" : "c");
            7: s = "/*x*y*/";
            8: s = "\"s\\\"t\"";
            9: s = "// c\n";
            10: s = string'(8'($urandom_range(1, 255)));
            default: s = " ";
        endcase
        return s;
    endfunction

    task automatic test_random(input int words);
        string s;
        int start;
        int done;
        start = words_sent;
        while (words_sent - start < words) begin
            done = words_sent - start;
            tx_idle_en = !(done >= words / 4 && done < (3 * words) / 4);
            rx_idle_en = tx_idle_en;
            s = rand_fragment();
            send_text(s, $urandom_range(0, 19) == 0);
            if ($urandom_range(0, 29) == 0) send_word(8'($urandom), 1'($urandom));
        end
        tx_idle_en = 1;
        rx_idle_en = 1;
        send_word(" ", 1);
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        send_text("a+b;c-d;[1]%2^3,4:5", 1);
        while (rx_hold > 0) @(posedge aclk);
    endtask

    task automatic test_pause();
        send_text("k<=7;", 0);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat ($urandom_range(5, 40)) @(posedge aclk);
        send_text("k>>=2;", 1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_end_of_source = 1'b0;
        m_ready = 1'b0;
        rx_hold = 0;
        tx_idle_en = 1;
        rx_idle_en = 1;
        errors = 0; words_sent = 0; tokens_seen = 0; full_seen = 0;
        mode = LX_IDLE; run_hash = 0; name_len = 0; num_acc = 0;
        pend_op = 0; quote_ch = 0; lit_ch = 0; tbl_used = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(30);
        test_backpressure();
        test_pause();
        drain();

        $display("Sent %0d words, checked %0d tokens (%0d with table full).",
                 words_sent, tokens_seen, full_seen);
        $display("Covered operators, literals, comments, long names, stalls and pauses.");
        if (errors == 0 && token_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/clx_pkg.sv
sv/clx_ram.sv
sv/clx_queue.sv
sv/clx_front.sv
sv/clx_back.sv
sv/c_source_lexer_core.sv
tb/sv/c_source_lexer_core_tb.sv
